// ----- sv/uniform_quantizer_run_histogram_defines.svh -----
// Assertion helpers for the quantiser block
`ifndef UNIFORM_QUANTIZER_RUN_HISTOGRAM_DEFINES_SVH
`define UNIFORM_QUANTIZER_RUN_HISTOGRAM_DEFINES_SVH
// implication checked on every edge outside reset
`define UQ_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
// next-cycle implication
`define UQ_ASSERT_NXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`endif

// ----- sv/uqrh_pkg.sv -----
`timescale 1ns / 1ps
package uqrh_pkg;
  localparam int LEVEL_BINS_DEF  = 256;
  localparam int RUN_BINS_DEF    = 1024;
  localparam int COUNT_WIDTH_DEF = 24;

  localparam logic [1:0] OP_QUANT = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] TSEL_LEVEL = 2'd0;
  localparam logic [1:0] TSEL_ZERO  = 2'd1;
  localparam logic [1:0] TSEL_NZ    = 2'd2;

  localparam logic [1:0] REG_BIN  = 2'd0;
  localparam logic [1:0] REG_MIN  = 2'd1;
  localparam logic [1:0] REG_MAX  = 2'd2;
  localparam logic [1:0] REG_MODE = 2'd3;

  // statistics modes
  localparam logic [1:0] MODE_LEVEL = 2'd0;
  localparam logic [1:0] MODE_ZRUN  = 2'd1;
  localparam logic [1:0] MODE_BOTH  = 2'd2;

  // table code used by the datapath bump ports
  typedef enum logic [1:0] {
    TAB_LEVEL = 2'd0,
    TAB_ZERO  = 2'd1,
    TAB_NZ    = 2'd2,
    TAB_NONE  = 2'd3
  } tab_t;

  // controller -> datapath
  typedef struct packed {
    logic start_div;   // load divider
    logic div_step;    // one quotient bit
    logic finish_q;    // sign, clamp, recon, stats decide
    logic bump_rd;     // issue read of bump slot
    logic bump_wr;     // write back bumped slot
    logic bump_next;   // advance bump slot
    logic do_read;     // issue histogram read
    logic clr_wr;      // write zero at clear address
    logic clr_start;
    logic load_out;
    logic out_zero;    // unknown operation
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic bump_last;
    logic clr_done;
  } sts_t;
endpackage

// ----- sv/uqrh_if.sv -----
`timescale 1ns / 1ps
interface uqrh_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic signed [19:0] sample;
  logic              row_end;
  logic [1:0]        table_select;
  logic [9:0]        bin_index;
  modport source (output valid, operation, sample, row_end, table_select, bin_index,
                  input ready);
  modport sink   (input valid, operation, sample, row_end, table_select, bin_index,
                  output ready);
endinterface

interface uqrh_out_if;
  logic               valid;
  logic               ready;
  logic signed [7:0]  level;
  logic signed [23:0] recon;
  logic [23:0]        bin_count;
  modport source (output valid, level, recon, bin_count, input ready);
  modport sink   (input valid, level, recon, bin_count, output ready);
endinterface

// ----- sv/uqrh_ctrl.sv -----
`timescale 1ns / 1ps
`include "uniform_quantizer_run_histogram_defines.svh"
module uqrh_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_op,
  input  logic             out_busy,
  input  uqrh_pkg::sts_t   sts,
  output uqrh_pkg::cmd_t   cmd
);
  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_FIN   = 9'b000001000,
    S_BRD   = 9'b000010000,
    S_BWR   = 9'b000100000,
    S_RD    = 9'b001000000,
    S_RD2   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   zero_r, zero_nxt;

  assign in_ready = (state_r == S_IDLE) && !out_busy;

  always_comb begin
    state_nxt = state_r;
    zero_nxt  = zero_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_OUT;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          zero_nxt = 1'b0;
          case (in_op)
            uqrh_pkg::OP_QUANT: begin
              cmd.start_div = 1'b1;
              state_nxt = S_DIV;
            end
            uqrh_pkg::OP_READ: begin
              cmd.do_read = 1'b1;
              state_nxt = S_RD;
            end
            uqrh_pkg::OP_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_nxt = S_CLEAR;
            end
            default: begin
              zero_nxt  = 1'b1;
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish_q = 1'b1;
        state_nxt = S_BRD;
      end
      S_BRD: begin
        cmd.bump_rd = 1'b1;
        state_nxt = S_BWR;
      end
      S_BWR: begin
        cmd.bump_wr = 1'b1;
        cmd.bump_next = 1'b1;
        state_nxt = sts.bump_last ? S_OUT : S_BRD;
      end
      S_RD:  state_nxt = S_RD2;
      S_RD2: state_nxt = S_OUT;
      S_OUT: begin
        cmd.load_out = 1'b1;
        cmd.out_zero = zero_r;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      zero_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      zero_r  <= zero_nxt;
    end
  end

  `UQ_ASSERT_IMP(a_rdy_idle, in_ready, state_r == S_IDLE, "ready outside idle")
  `UQ_ASSERT_NXT(a_out_idle, state_r == S_OUT, state_r == S_IDLE, "out not followed by idle")
  `UQ_ASSERT_IMP(a_oh, 1'b1, $onehot(state_r), "state not one-hot")
endmodule

// ----- sv/uqrh_dp.sv -----
`timescale 1ns / 1ps
`include "uniform_quantizer_run_histogram_defines.svh"
module uqrh_dp #(
  parameter int LEVEL_BINS  = uqrh_pkg::LEVEL_BINS_DEF,
  parameter int RUN_BINS    = uqrh_pkg::RUN_BINS_DEF,
  parameter int COUNT_WIDTH = uqrh_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  uqrh_pkg::cmd_t     cmd,
  output uqrh_pkg::sts_t     sts,
  input  logic [1:0]         in_op,
  input  logic [19:0]        in_sample,
  input  logic               in_row_end,
  input  logic [1:0]         in_sel,
  input  logic [9:0]         in_idx,
  input  logic               in_acc,
  input  logic [15:0]        bin_size,
  input  logic signed [7:0]  min_level,
  input  logic [6:0]         max_level,
  input  logic [1:0]         stats_mode,
  output logic signed [7:0]  res_level,
  output logic signed [23:0] res_recon,
  output logic [23:0]        res_count
);
  localparam int LW = $clog2(LEVEL_BINS);
  localparam int RW = $clog2(RUN_BINS);
  localparam int CW = (LW > RW) ? LW : RW;
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
  localparam logic [RW-1:0] RUN_SAT = RW'(RUN_BINS - 1);

  // memories
  logic [COUNT_WIDTH-1:0] lv_mem [LEVEL_BINS];
  logic [COUNT_WIDTH-1:0] zr_mem [RUN_BINS];
  logic [COUNT_WIDTH-1:0] nz_mem [RUN_BINS];
  logic [COUNT_WIDTH-1:0] lv_q, zr_q, nz_q;

  // divider: (2*mag + b) / (2*b), restoring, 22 quotient bits
  logic [21:0] num_r;
  logic [22:0] rem_r;
  logic [16:0] den_r;
  logic [4:0]  cnt_r;
  logic        neg_r, last_r;
  logic [1:0]  mode_r;
  logic [15:0] b_r;

  logic [22:0] rem_sh, rem_sub;
  always_comb begin
    rem_sh  = {rem_r[21:0], num_r[21]};
    rem_sub = rem_sh - {6'd0, den_r};
  end

  logic [20:0] mag;
  always_comb begin
    mag = in_sample[19] ? (21'h100000 - {1'b0, in_sample}) : {1'b0, in_sample};
  end

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      b_r    <= (bin_size == 16'd0) ? 16'd1 : bin_size;
      den_r  <= {((bin_size == 16'd0) ? 16'd1 : bin_size), 1'b0};
      num_r  <= {mag, 1'b0} + {6'd0, ((bin_size == 16'd0) ? 16'd1 : bin_size)};
      rem_r  <= '0;
      cnt_r  <= '0;
      neg_r  <= in_sample[19];
      last_r <= in_row_end;
      mode_r <= stats_mode;
    end else if (cmd.div_step) begin
      if (!rem_sub[22]) begin
        rem_r <= rem_sub;
      end else begin
        rem_r <= rem_sh;
      end
      num_r <= {num_r[20:0], ~rem_sub[22]};
      cnt_r <= cnt_r + 5'd1;
    end
  end
  assign sts.div_done = cnt_r == 5'd21;

  // quotient in num_r after 22 steps; narrow it and clamp
  logic signed [9:0] lv_c;
  always_comb begin
    logic [21:0] q;
    logic signed [23:0] sq;
    q  = num_r;
    sq = neg_r ? -$signed({2'b00, q}) : $signed({2'b00, q});
    if (sq < 24'(min_level)) sq = 24'(min_level);
    if (sq > $signed({17'd0, max_level})) sq = $signed({17'd0, max_level});
    lv_c = 10'(sq);
  end

  // run state and bump list (up to three bumps)
  logic              zrun_r, zrun_nxt;
  logic [RW-1:0]     rlen_r, rlen_nxt;
  uqrh_pkg::tab_t    btab_r [3];
  logic [CW-1:0]     baddr_r [3];
  logic [1:0]        bslot_r;
  logic signed [7:0] lev_r;
  logic [23:0]       recon_r;
  uqrh_pkg::tab_t    bt [3];
  logic [CW-1:0]     ba [3];

  function automatic logic [CW-1:0] lvidx(input logic signed [7:0] lv);
    logic signed [15:0] i;
    i = 16'(lv) + 16'(LEVEL_BINS / 2);
    if (i < 0) i = 0;
    if (i > 16'(LEVEL_BINS - 1)) i = 16'(LEVEL_BINS - 1);
    return CW'(i);
  endfunction

  always_comb begin
    logic signed [7:0] lv;
    logic nzl;
    lv = lv_c[7:0];
    nzl = lv != 8'sd0;
    zrun_nxt = zrun_r;
    rlen_nxt = rlen_r;
    for (int k = 0; k < 3; k++) begin
      bt[k] = uqrh_pkg::TAB_NONE;
      ba[k] = '0;
    end
    if (mode_r == uqrh_pkg::MODE_ZRUN) begin
      if (zrun_r && nzl) begin
        if (rlen_r != '0) begin
          bt[0] = uqrh_pkg::TAB_ZERO;  ba[0] = CW'(rlen_r);
          bt[1] = uqrh_pkg::TAB_LEVEL; ba[1] = lvidx(8'sd0);
        end
        rlen_nxt = '0;
        zrun_nxt = 1'b0;
        bt[2] = uqrh_pkg::TAB_LEVEL; ba[2] = lvidx(lv);
      end else if (zrun_r) begin
        if (rlen_r < RUN_SAT) rlen_nxt = rlen_r + 1'b1;
      end else if (nzl) begin
        bt[0] = uqrh_pkg::TAB_LEVEL; ba[0] = lvidx(lv);
      end else begin
        rlen_nxt = RW'(1);
        zrun_nxt = 1'b1;
      end
      // row end: zero run can only be open if no bump was issued above
      if (last_r && zrun_nxt && rlen_nxt != '0) begin
        bt[0] = uqrh_pkg::TAB_ZERO;  ba[0] = CW'(rlen_nxt);
        bt[1] = uqrh_pkg::TAB_LEVEL; ba[1] = lvidx(8'sd0);
      end
    end else if (mode_r == uqrh_pkg::MODE_BOTH) begin
      if (zrun_r && nzl) begin
        bt[0] = uqrh_pkg::TAB_ZERO; ba[0] = CW'(rlen_r);
        rlen_nxt = RW'(1);
        zrun_nxt = 1'b0;
        bt[1] = uqrh_pkg::TAB_LEVEL; ba[1] = lvidx(lv);
      end else if (zrun_r) begin
        if (rlen_r < RUN_SAT) rlen_nxt = rlen_r + 1'b1;
      end else if (nzl) begin
        if (rlen_r < RUN_SAT) rlen_nxt = rlen_r + 1'b1;
        bt[1] = uqrh_pkg::TAB_LEVEL; ba[1] = lvidx(lv);
      end else begin
        bt[0] = uqrh_pkg::TAB_NZ; ba[0] = CW'(rlen_r);
        rlen_nxt = RW'(1);
        zrun_nxt = 1'b1;
      end
      if (last_r) begin
        bt[2] = zrun_nxt ? uqrh_pkg::TAB_ZERO : uqrh_pkg::TAB_NZ;
        ba[2] = CW'(rlen_nxt);
      end
    end else begin
      bt[0] = uqrh_pkg::TAB_LEVEL; ba[0] = lvidx(lv);
    end
    if (last_r) begin
      zrun_nxt = 1'b1;
      rlen_nxt = '0;
    end
  end

  // bump engine: read slot, then write slot+1 (saturating)
  uqrh_pkg::tab_t cur_tab;
  logic [CW-1:0]  cur_addr;
  logic [COUNT_WIDTH-1:0] cur_q, inc_q;
  assign cur_tab  = btab_r[bslot_r];
  assign cur_addr = baddr_r[bslot_r];
  assign sts.bump_last = bslot_r == 2'd2;

  // clear sweep
  logic [CW:0] clr_r;
  assign sts.clr_done = clr_r == (CW+1)'((LEVEL_BINS > RUN_BINS) ? LEVEL_BINS - 1 :
                                         RUN_BINS - 1);

  always_comb begin
    case (cur_tab)
      uqrh_pkg::TAB_ZERO: cur_q = zr_q;
      uqrh_pkg::TAB_NZ:   cur_q = nz_q;
      default:            cur_q = lv_q;
    endcase
    inc_q = (cur_q == CMAX) ? cur_q : cur_q + 1'b1;
  end

  // read address shared by bump and histogram read
  logic [CW-1:0] raddr;
  logic [1:0]    rsel_r;
  logic          rok_r;
  always_comb begin
    raddr = cmd.do_read ? CW'(in_idx) : cur_addr;
  end

  always_ff @(posedge clk) begin
    if (cmd.do_read || cmd.bump_rd) begin
      lv_q <= lv_mem[raddr[LW-1:0]];
      zr_q <= zr_mem[raddr[RW-1:0]];
      nz_q <= nz_mem[raddr[RW-1:0]];
    end
    if (cmd.clr_wr) begin
      if (clr_r < (CW+1)'(LEVEL_BINS)) lv_mem[clr_r[LW-1:0]] <= '0;
      if (clr_r < (CW+1)'(RUN_BINS)) begin
        zr_mem[clr_r[RW-1:0]] <= '0;
        nz_mem[clr_r[RW-1:0]] <= '0;
      end
    end else if (cmd.bump_wr) begin
      case (cur_tab)
        uqrh_pkg::TAB_LEVEL: lv_mem[cur_addr[LW-1:0]] <= inc_q;
        uqrh_pkg::TAB_ZERO:  zr_mem[cur_addr[RW-1:0]] <= inc_q;
        uqrh_pkg::TAB_NZ:    nz_mem[cur_addr[RW-1:0]] <= inc_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zrun_r    <= 1'b1;
      rlen_r    <= '0;
      clr_r     <= '0;
      bslot_r   <= '0;
    end else begin
      if (cmd.clr_start) begin
        clr_r     <= '0;
        zrun_r    <= 1'b1;
        rlen_r    <= '0;
      end else if (cmd.clr_wr) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.finish_q) begin
        zrun_r  <= zrun_nxt;
        rlen_r  <= rlen_nxt;
        bslot_r <= '0;
      end else if (cmd.bump_next) begin
        bslot_r <= (bslot_r == 2'd2) ? 2'd0 : bslot_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_q) begin
      for (int k = 0; k < 3; k++) begin
        btab_r[k]  <= bt[k];
        baddr_r[k] <= ba[k];
      end
      lev_r   <= lv_c[7:0];
      recon_r <= 24'($signed(lv_c[7:0]) * $signed({1'b0, b_r}));
    end
    if (in_acc) begin
      rsel_r <= in_sel;
      rok_r  <= (in_sel == uqrh_pkg::TSEL_LEVEL) ? (32'(in_idx) < LEVEL_BINS)
              : (in_sel == uqrh_pkg::TSEL_ZERO || in_sel == uqrh_pkg::TSEL_NZ)
                ? (32'(in_idx) < RUN_BINS) : 1'b0;
    end
  end

  // result assembly
  logic [COUNT_WIDTH-1:0] rd_c;
  always_comb begin
    case (rsel_r)
      uqrh_pkg::TSEL_LEVEL: rd_c = lv_q;
      uqrh_pkg::TSEL_ZERO:  rd_c = zr_q;
      default:              rd_c = nz_q;
    endcase
    res_level = '0;
    res_recon = '0;
    res_count = '0;
    if (!cmd.out_zero) begin
      if (in_op == uqrh_pkg::OP_QUANT) begin
        res_level = lev_r;
        res_recon = recon_r;
      end else if (in_op == uqrh_pkg::OP_READ && rok_r) begin
        res_count = 24'(rd_c);
      end
    end
  end

  `UQ_ASSERT_NXT(a_div_len, cmd.start_div, cnt_r == 5'd0, "divider not restarted")
  `UQ_ASSERT_IMP(a_no_mix, cmd.clr_wr, !cmd.bump_wr, "clear and bump collide")
  `UQ_ASSERT_IMP(a_lvl_rng, cmd.finish_q,
                 lv_c <= 10'sd127 && lv_c >= -10'sd128, "level out of range")
endmodule

// ----- sv/uniform_quantizer_run_histogram.sv -----
`timescale 1ns / 1ps
// Uniform quantiser with run-length statistics. One beat in, one beat out, one item
// at a time. A quantise runs a 22-step restoring divider, a finish step and three
// read/write bump pairs on the histogram RAMs before its result is loaded. A read
// passes through the RAM read states first; an unknown operation goes straight to
// the output state. After reset and on a clear the block sweeps all max(LEVEL_BINS,
// RUN_BINS) table addresses, accepting no beat meanwhile. Registers via APB at 4*i.
module uniform_quantizer_run_histogram #(
  parameter int LEVEL_BINS  = uqrh_pkg::LEVEL_BINS_DEF,
  parameter int RUN_BINS    = uqrh_pkg::RUN_BINS_DEF,
  parameter int COUNT_WIDTH = uqrh_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  uqrh_in_if.sink     in_ch,
  uqrh_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  uqrh_pkg::cmd_t cmd;
  uqrh_pkg::sts_t sts;

  logic [15:0]       bin_r;
  logic signed [7:0] min_r;
  logic [6:0]        max_r;
  logic [1:0]        mode_r;
  logic [1:0]        op_r;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_r  <= 16'd16;
      min_r  <= -8'sd128;
      max_r  <= 7'd127;
      mode_r <= uqrh_pkg::MODE_LEVEL;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[3:2])
        uqrh_pkg::REG_BIN:  bin_r  <= cfg_pwdata[15:0];
        uqrh_pkg::REG_MIN:  min_r  <= cfg_pwdata[7:0];
        uqrh_pkg::REG_MAX:  max_r  <= cfg_pwdata[6:0];
        uqrh_pkg::REG_MODE: mode_r <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (cfg_paddr[3:2])
      uqrh_pkg::REG_BIN:  cfg_prdata = {16'd0, bin_r};
      uqrh_pkg::REG_MIN:  cfg_prdata = {24'd0, min_r};
      uqrh_pkg::REG_MAX:  cfg_prdata = {25'd0, max_r};
      default:            cfg_prdata = {30'd0, mode_r};
    endcase
  end

  logic in_acc;
  assign in_acc = in_ch.valid && in_ch.ready;
  always_ff @(posedge clk) begin
    if (in_acc) op_r <= in_ch.operation;
  end

  // reset sweep also ends in the out state; suppress that beat
  logic boot_r;
  always_ff @(posedge clk) begin
    if (!rst_n) boot_r <= 1'b1;
    else if (cmd.load_out) boot_r <= 1'b0;
  end

  // output register
  logic              ov_r;
  logic signed [7:0] lev;
  logic signed [23:0] rec;
  logic [23:0]       cnt;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.load_out && !boot_r) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
    if (cmd.load_out) begin
      out_ch.level     <= lev;
      out_ch.recon     <= rec;
      out_ch.bin_count <= cnt;
    end
  end
  assign out_ch.valid = ov_r;

  uqrh_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid && !boot_r),
    .in_ready (in_ch.ready),
    .in_op    (in_ch.operation),
    .out_busy (ov_r),
    .sts, .cmd
  );

  uqrh_dp #(.LEVEL_BINS(LEVEL_BINS), .RUN_BINS(RUN_BINS), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_op      (op_r),
    .in_sample  (in_ch.sample),
    .in_row_end (in_ch.row_end),
    .in_sel     (in_ch.table_select),
    .in_idx     (in_ch.bin_index),
    .in_acc,
    .bin_size   (bin_r),
    .min_level  (min_r),
    .max_level  (max_r),
    .stats_mode (mode_r),
    .res_level  (lev),
    .res_recon  (rec),
    .res_count  (cnt)
  );
endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
module tb;
  // statistics modes as held in the mode register
  localparam logic [1:0] SMODE_LEVEL = uqrh_pkg::MODE_LEVEL;
  localparam logic [1:0] SMODE_ZRUN  = uqrh_pkg::MODE_ZRUN;
  localparam logic [1:0] SMODE_BOTH  = uqrh_pkg::MODE_BOTH;
  localparam logic [1:0] SMODE_SPARE = 2'd3;
  localparam logic [1:0] OP_SPARE    = 2'd3;
  localparam logic [1:0] TSEL_SPARE  = 2'd3;

  localparam int NLEV    = uqrh_pkg::LEVEL_BINS_DEF;
  localparam int NRUN    = uqrh_pkg::RUN_BINS_DEF;
  localparam int CNT_TOP = (1 << uqrh_pkg::COUNT_WIDTH_DEF) - 1;
  // generous margin over a full clear sweep and the long receiver hold
  localparam int STALL_LIMIT = 6000;

  typedef struct packed {
    logic signed [7:0]  level;
    logic signed [23:0] recon;
    logic [23:0]        bin_count;
  } quant_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic       cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  uqrh_in_if  in_if ();
  uqrh_out_if out_if ();

  uniform_quantizer_run_histogram DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor state: shadow registers and the three histograms
  // ---------------------------------------------------------------------
  int unsigned lvl_tab [NLEV];
  int unsigned zrun_tab [NRUN];
  int unsigned nzrun_tab [NRUN];
  bit          zero_open;   // currently inside a run of zero levels
  int unsigned run_len;

  int unsigned sh_bin  = 16;
  int          sh_min  = -128;
  int          sh_max  = 127;
  logic [1:0]  sh_mode = SMODE_LEVEL;

  quant_res_t  pending_q[$];
  int          errors = 0;
  int          n_beats_in = 0, n_beats_out = 0, n_quant = 0, n_reads = 0;

  function automatic void inc_lvl(input int lv);
    int idx;
    idx = lv + NLEV / 2;
    if (idx < 0) idx = 0;
    if (idx > NLEV - 1) idx = NLEV - 1;
    if (lvl_tab[idx] < CNT_TOP) lvl_tab[idx]++;
  endfunction

  function automatic void inc_zrun(input int unsigned idx);
    if (idx < NRUN && zrun_tab[idx] < CNT_TOP) zrun_tab[idx]++;
  endfunction

  function automatic void inc_nzrun(input int unsigned idx);
    if (idx < NRUN && nzrun_tab[idx] < CNT_TOP) nzrun_tab[idx]++;
  endfunction

  function automatic void grow_run();
    if (run_len < NRUN - 1) run_len++;
  endfunction

  function automatic void wipe_tables();
    foreach (lvl_tab[i]) lvl_tab[i] = 0;
    foreach (zrun_tab[i]) zrun_tab[i] = 0;
    foreach (nzrun_tab[i]) nzrun_tab[i] = 0;
    zero_open = 1'b1;
    run_len = 0;
  endfunction

  // zero-run statistics: nonzero levels counted, each closed zero run recorded
  // in the run table and once more at the zero-level slot
  function automatic void stats_zrun(input int lv, input bit last);
    if (zero_open && lv != 0) begin
      if (run_len > 0) begin
        inc_zrun(run_len);
        inc_lvl(0);
      end
      run_len = 0;
      zero_open = 1'b0;
      inc_lvl(lv);
    end else if (zero_open) begin
      grow_run();
    end else if (lv != 0) begin
      inc_lvl(lv);
    end else begin
      run_len = 1;
      zero_open = 1'b1;
    end
    if (last && zero_open && run_len != 0) begin
      inc_zrun(run_len);
      inc_lvl(0);
    end
  endfunction

  // both run tables, levels counted except zeros
  function automatic void stats_both(input int lv, input bit last);
    if (zero_open && lv != 0) begin
      inc_zrun(run_len);
      run_len = 1;
      zero_open = 1'b0;
      inc_lvl(lv);
    end else if (zero_open) begin
      grow_run();
    end else if (lv != 0) begin
      grow_run();
      inc_lvl(lv);
    end else begin
      inc_nzrun(run_len);
      run_len = 1;
      zero_open = 1'b1;
    end
    if (last) begin
      if (zero_open) inc_zrun(run_len);
      else inc_nzrun(run_len);
    end
  endfunction

  function automatic quant_res_t quantise_beat(input logic [1:0] op,
                                               input logic [19:0] smp,
                                               input logic last,
                                               input logic [1:0] sel,
                                               input logic [9:0] idx);
    quant_res_t r;
    int unsigned b, mag, q;
    int lv;
    longint rec;
    r = '0;
    case (op)
      uqrh_pkg::OP_QUANT: begin
        b = (sh_bin != 0) ? sh_bin : 1;
        mag = smp[19] ? ((32'h100000 - {12'd0, smp}) & 32'h1FFFFF) : {12'd0, smp};
        q = (2 * mag + b) / (2 * b);
        lv = smp[19] ? -int'(q) : int'(q);
        // lower clamp first, so the upper bound wins if they cross
        if (lv < sh_min) lv = sh_min;
        if (lv > sh_max) lv = sh_max;
        rec = longint'(lv) * longint'(b);
        if (sh_mode == SMODE_ZRUN) stats_zrun(lv, last);
        else if (sh_mode == SMODE_BOTH) stats_both(lv, last);
        else inc_lvl(lv);
        if (last) begin
          zero_open = 1'b1;
          run_len = 0;
        end
        r.level = lv[7:0];
        r.recon = rec[23:0];
      end
      uqrh_pkg::OP_READ: begin
        if (sel == uqrh_pkg::TSEL_LEVEL && idx < NLEV) r.bin_count = 24'(lvl_tab[idx]);
        else if (sel == uqrh_pkg::TSEL_ZERO && idx < NRUN) r.bin_count = 24'(zrun_tab[idx]);
        else if (sel == uqrh_pkg::TSEL_NZ && idx < NRUN) r.bin_count = 24'(nzrun_tab[idx]);
      end
      uqrh_pkg::OP_CLEAR: wipe_tables();
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Sender: bursts with random gaps, beats change at the falling edge
  // ---------------------------------------------------------------------
  int  burst_left = 0;
  bit  no_gaps = 1'b0;

  initial begin
    in_if.valid = 1'b0;
    in_if.operation = uqrh_pkg::OP_QUANT;
    in_if.sample = '0;
    in_if.row_end = 1'b0;
    in_if.table_select = uqrh_pkg::TSEL_LEVEL;
    in_if.bin_index = '0;
  end

  task automatic send_beat(input logic [1:0] op, input logic [19:0] smp,
                           input logic last, input logic [1:0] sel,
                           input logic [9:0] idx);
    if (!no_gaps && burst_left == 0) begin
      @(negedge clk);
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end else begin
      @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_if.valid = 1'b1;
    in_if.operation = op;
    in_if.sample = smp;
    in_if.row_end = last;
    in_if.table_select = sel;
    in_if.bin_index = idx;
    do @(posedge clk); while (!in_if.ready);
    pending_q.push_back(quantise_beat(op, smp, last, sel, idx));
    n_beats_in++;
    if (op == uqrh_pkg::OP_QUANT) n_quant++;
    if (op == uqrh_pkg::OP_READ) n_reads++;
  endtask

  task automatic quant(input logic [19:0] smp, input logic last = 1'b0);
    send_beat(uqrh_pkg::OP_QUANT, smp, last, uqrh_pkg::TSEL_LEVEL, 10'd0);
  endtask

  task automatic rd(input logic [1:0] sel, input logic [9:0] idx);
    send_beat(uqrh_pkg::OP_READ, 20'($urandom), 1'b0, sel, idx);
  endtask

  // wait until every expected beat has come back, with valid dropped
  task automatic drain();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // APB write: setup then access phase, only with the block idle
  task automatic reg_write(input logic [1:0] regi, input logic [31:0] val);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = {regi, 2'b00};
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (regi)
      uqrh_pkg::REG_BIN: sh_bin = {16'd0, val[15:0]};
      uqrh_pkg::REG_MIN: sh_min = int'($signed(val[7:0]));
      uqrh_pkg::REG_MAX: sh_max = int'(val[6:0]);
      default: sh_mode = val[1:0];
    endcase
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic set_all(input int bin, input int mn, input int mx, input logic [1:0] md);
    drain();
    reg_write(uqrh_pkg::REG_BIN, bin);
    reg_write(uqrh_pkg::REG_MIN, mn);
    reg_write(uqrh_pkg::REG_MAX, mx);
    reg_write(uqrh_pkg::REG_MODE, {30'd0, md});
  endtask

  // ---------------------------------------------------------------------
  // Receiver: stall pattern switches every so often; a test may ask for a
  // long hold, which is counted here
  // ---------------------------------------------------------------------
  int hold_req = 0;
  int rcv_style = 0;
  int rcv_left = 0;

  initial out_if.ready = 1'b0;

  always @(negedge clk) begin
    if (hold_req > 0) begin
      out_if.ready = 1'b0;
      hold_req--;
    end else begin
      if (rcv_left == 0) begin
        rcv_style = $urandom_range(0, 2);
        rcv_left = $urandom_range(20, 150);
      end
      rcv_left--;
      case (rcv_style)
        0: out_if.ready = 1'b1;
        1: out_if.ready = ($urandom_range(0, 9) < 7);
        default: out_if.ready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: each beat against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    quant_res_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      n_beats_out++;
      if (pending_q.size() == 0) begin
        $error("unexpected result beat: level %0d recon %0d bin_count %0d",
               out_if.level, out_if.recon, out_if.bin_count);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_if.level !== e.level) begin
          $error("level: expected %0d, got %0d", e.level, out_if.level);
          errors++;
        end
        if (out_if.recon !== e.recon) begin
          $error("recon: expected %0d, got %0d", e.recon, out_if.recon);
          errors++;
        end
        if (out_if.bin_count !== e.bin_count) begin
          $error("bin_count: expected %0d, got %0d", e.bin_count, out_if.bin_count);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat or register write
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_psel && cfg_penable) || !rst_n) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // sample extremes, rounding at the half step, every operation, odd selects
  task automatic test_directed();
    quant(20'h7FFFF);
    quant(20'h80000);
    quant(20'h00000);
    quant(20'h00008);               // exactly half a step up
    quant(20'hFFFF8);               // exactly half a step down
    quant(20'h00007);
    quant(20'h00018, 1'b1);
    rd(uqrh_pkg::TSEL_LEVEL, 10'd128);
    rd(uqrh_pkg::TSEL_LEVEL, 10'd255);
    rd(uqrh_pkg::TSEL_LEVEL, 10'd0);
    rd(uqrh_pkg::TSEL_LEVEL, 10'd300);        // beyond the level table
    rd(TSEL_SPARE, 10'd128);                  // unknown table
    rd(uqrh_pkg::TSEL_ZERO, 10'd1023);
    rd(uqrh_pkg::TSEL_NZ, 10'd1023);
    send_beat(OP_SPARE, 20'hFFFFF, 1'b1, TSEL_SPARE, 10'h3FF);
    send_beat(uqrh_pkg::OP_CLEAR, 20'h12345, 1'b0, uqrh_pkg::TSEL_NZ, 10'h155);
    rd(uqrh_pkg::TSEL_LEVEL, 10'd128);
    // zero bin size behaves as one; crossed bounds let the upper one win
    set_all(0, 5, 3, SMODE_SPARE);
    quant(20'h00000);
    quant(20'hFFF00);
    quant(20'h7FFFF, 1'b1);
    rd(uqrh_pkg::TSEL_LEVEL, 10'd131);
    set_all(65535, -128, 127, SMODE_LEVEL);
    quant(20'h7FFFF);
    quant(20'h80000);
    rd(uqrh_pkg::TSEL_LEVEL, 10'd136);
  endtask

  // one row long enough to saturate the run length, then its histogram
  task automatic test_long_run();
    set_all(4096, -128, 127, SMODE_BOTH);
    send_beat(uqrh_pkg::OP_CLEAR, '0, 1'b0, uqrh_pkg::TSEL_LEVEL, '0);
    quant(20'h01000);
    for (int i = 0; i < 1030; i++) quant(20'($urandom_range(0, 2047)), i == 1029);
    rd(uqrh_pkg::TSEL_ZERO, 10'd1023);
    rd(uqrh_pkg::TSEL_NZ, 10'd1);
    rd(uqrh_pkg::TSEL_ZERO, 10'd1022);
  endtask

  // receiver holds off a long time while the sender keeps offering beats
  task automatic test_backpressure();
    drain();
    hold_req = 300;
    no_gaps = 1'b1;
    for (int i = 0; i < 12; i++) quant(20'($urandom));
    no_gaps = 1'b0;
  endtask

  function automatic logic [19:0] rand_sample();
    int unsigned k;
    int unsigned mag;
    k = $urandom_range(0, 9);
    if (k < 4) return 20'($urandom_range(0, sh_bin / 2));      // mostly zeros
    if (k < 8) begin
      mag = $urandom_range(0, sh_bin * 6 + 8);
      if (mag > 20'h7FFFF) mag = 20'h7FFFF;
      return $urandom_range(0, 1) ? 20'(mag) : 20'(-int'(mag));
    end
    return 20'($urandom);
  endfunction

  // rows of random samples with reads sprinkled in and the odd clear
  task automatic test_random_phase(input int n_items);
    int k;
    for (int i = 0; i < n_items; i++) begin
      k = $urandom_range(0, 99);
      if (k < 78) begin
        quant(rand_sample(), $urandom_range(0, 11) == 0);
      end else if (k < 95) begin
        case ($urandom_range(0, 3))
          0: rd(uqrh_pkg::TSEL_LEVEL, 10'($urandom_range(0, 255)));
          1: rd(uqrh_pkg::TSEL_ZERO, 10'($urandom_range(0, 12)));
          2: rd(uqrh_pkg::TSEL_NZ, 10'($urandom_range(0, 12)));
          default: rd(2'($urandom), 10'($urandom));
        endcase
      end else if (k < 98) begin
        send_beat(OP_SPARE, 20'($urandom), 1'($urandom), 2'($urandom), 10'($urandom));
      end else begin
        send_beat(uqrh_pkg::OP_CLEAR, 20'($urandom), 1'($urandom), 2'($urandom),
                  10'($urandom));
      end
    end
  endtask

  task automatic test_random();
    set_all(16, -128, 127, SMODE_LEVEL);
    test_random_phase(80);
    set_all(16, -4, 4, SMODE_ZRUN);
    test_random_phase(90);
    set_all(1, 0, 0, SMODE_ZRUN);
    test_random_phase(40);
    set_all(40, -20, 127, SMODE_BOTH);
    test_random_phase(90);
    set_all(65535, -128, 127, SMODE_BOTH);
    test_random_phase(40);
    set_all(3, -128, 0, SMODE_SPARE);
    test_random_phase(50);
    for (int p = 0; p < 3; p++) begin
      set_all($urandom_range(1, 200), -int'($urandom_range(0, 128)),
              $urandom_range(0, 127), 2'($urandom_range(0, 2)));
      test_random_phase(70);
    end
  endtask

  initial begin
    wipe_tables();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_long_run();
    test_backpressure();
    test_random();
    drain();
    $display("Ran %0d beats in, %0d out: %0d quantises, %0d table reads,",
             n_beats_in, n_beats_out, n_quant, n_reads);
    $display("over all statistics modes, clamp bounds and bin sizes incl. zero.");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
